/* rtl/amm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// amm_pkg
// Shared types and constants of the crosspoint audio matrix mixer.
// ============================================================================
package amm_pkg;

    // Field widths of the stream beats.
    localparam int CHAN_W     = 3;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int FUNC_W     = 2;
    localparam int ACC_W      = 40;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Largest channel count addressable by the channel fields, and the
    // largest number of results in one frame.
    localparam int MAX_CHAN = 8;
    localparam int MAX_EMIT = 8;

    // Unity gain in unsigned Q1.15.
    localparam logic [GAIN_W-1:0] UNITY = 16'h8000;

    // Configuration register indexes.
    localparam int          CFG_IDX_W  = 1;
    localparam logic [0:0]  CFG_MASTER = 1'b0;
    localparam logic [0:0]  CFG_ACTIVE = 1'b1;

    // Item kinds carried in tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_GAIN   = 2'd1,
        FUNC_VOL    = 2'd2
    } t_func;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_EMIT_RD,
        ST_EMIT_M1,
        ST_EMIT_M2,
        ST_EMIT_WR
    } t_state;

    // Load strobes of the output scaling pipeline.
    typedef struct packed {
        logic ld_vol;
        logic ld_master;
    } t_scale_ctl;

    // Clamp a gain to unity.
    function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] v);
        logic [GAIN_W-1:0] r;
        r = (v > UNITY) ? UNITY : v;
        return r;
    endfunction

endpackage

/* rtl/amm_gain_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// amm_gain_ram
// Crosspoint gain storage: one write port, one registered read port, and a
// valid bit per entry so that unwritten entries read as unity.
// ============================================================================
module amm_gain_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [amm_pkg::GAIN_W-1:0]    i_wr_data,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [amm_pkg::GAIN_W-1:0]    o_rd_data
);

    logic [amm_pkg::GAIN_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [amm_pkg::GAIN_W-1:0] r_rd_data;
    logic                       r_rd_valid;

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // Entry valid bits; reset returns every entry to unity at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : amm_pkg::UNITY;

endmodule

/* rtl/amm_acc_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// amm_acc_ram
// Output accumulator storage with a registered read port and per-entry valid
// bits; a cleared entry reads as zero.
// ============================================================================
module amm_acc_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr_all,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [amm_pkg::ACC_W-1:0]    i_wr_data,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [amm_pkg::ACC_W-1:0]    o_rd_data
);

    logic [amm_pkg::ACC_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]          r_valid;
    logic [amm_pkg::ACC_W-1:0] r_rd_data;
    logic                      r_rd_valid;

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // Valid bits: a write marks its entry, the frame end clears them all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clr_all) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/amm_scale.sv */
`timescale 1ns / 1ps
// ============================================================================
// amm_scale
// Output scaling: accumulator shifted by 15, times output volume, times
// master volume, each product arithmetic-shifted by 15, saturated to 16 bits.
// ============================================================================
module amm_scale (
    input  logic                            i_clk,
    input  amm_pkg::t_scale_ctl             i_ctl,
    input  logic [amm_pkg::ACC_W-1:0]       i_acc,
    input  logic [amm_pkg::GAIN_W-1:0]      i_vol,
    input  logic [amm_pkg::GAIN_W-1:0]      i_master,
    output logic [amm_pkg::SAMPLE_W-1:0]    o_sample,
    output logic                            o_clip
);

    logic signed [24:0] acc_q;
    logic signed [16:0] vol_s;
    logic signed [16:0] master_s;
    logic signed [41:0] n_m1;
    logic signed [41:0] r_m1;
    logic signed [26:0] m1_q;
    logic signed [43:0] n_m2;
    logic signed [43:0] r_m2;
    logic signed [28:0] m2_q;

    // First product: shifted accumulator times output volume.
    assign acc_q = $signed(i_acc[39:15]);
    assign vol_s = $signed({1'b0, i_vol});
    assign n_m1  = acc_q * vol_s;

    // Second product: shifted first product times master volume.
    assign m1_q     = r_m1[41:15];
    assign master_s = $signed({1'b0, i_master});
    assign n_m2     = m1_q * master_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_vol) begin
            r_m1 <= n_m1;
        end
        if (i_ctl.ld_master) begin
            r_m2 <= n_m2;
        end
    end

    // Saturate the final value to signed 16 bits.
    assign m2_q = r_m2[43:15];

    always_comb begin
        if (m2_q > 29'sd32767) begin
            o_sample = 16'h7FFF;
            o_clip   = 1'b1;
        end else if (m2_q < -29'sd32768) begin
            o_sample = 16'h8000;
            o_clip   = 1'b1;
        end else begin
            o_sample = m2_q[15:0];
            o_clip   = 1'b0;
        end
    end

endmodule

/* rtl/audio_matrix_mixer.sv */
`timescale 1ns / 1ps
// ============================================================================
// audio_matrix_mixer
// Crosspoint audio mixer with stored gain matrix, output and master volume.
// ============================================================================
// Items enter on the slave stream: tuser is the kind (sample, gain write,
// volume write), tlast marks the last sample of a frame. A sample sweeps the
// accumulator memory one output per cycle through a read, multiply, add and
// write-back pipeline, and holds the input until the sweep is done (outputs
// capped at eight). On a frame end, each active output is read, scaled by
// two registered multipliers and saturated, one result after another; the
// results leave on the master stream with tlast on the last one, and the
// accumulators are cleared. The output register holds a result while the
// receiver stalls; the emit sequence then waits, and no new item is taken
// until the frame is out. After the last result is loaded the next item is
// accepted even if that result has not been taken yet. Reset restores unity
// gains and volumes, an empty mix, master volume unity and eight active
// outputs. The configuration port is always ready and is to be written
// only while idle; the block itself does not enforce this.
// ============================================================================
module audio_matrix_mixer #(
    parameter int NUM_INPUTS  = 8,
    parameter int NUM_OUTPUTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] in_chan, [5:3] out_chan, [21:6] gain_value, [37:22] sample_value
    input  logic [amm_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] func
    input  logic [amm_pkg::FUNC_W-1:0]        i_s_tuser,
    input  logic                              i_s_tlast,
    // Master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [2:0] out_index, [18:3] mixed_sample
    output logic [amm_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // [0] clipped
    output logic                              o_m_tuser,
    output logic                              o_m_tlast,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [amm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [amm_pkg::GAIN_W-1:0]        i_cfg_data
);

    // Channels reachable through the 3-bit channel fields.
    localparam int N_IN  = (NUM_INPUTS  > amm_pkg::MAX_CHAN) ? amm_pkg::MAX_CHAN : NUM_INPUTS;
    localparam int N_OUT = (NUM_OUTPUTS > amm_pkg::MAX_EMIT) ? amm_pkg::MAX_EMIT : NUM_OUTPUTS;
    localparam int AW    = (N_OUT > 1) ? $clog2(N_OUT) : 1;
    localparam int CNT_W = $clog2(N_OUT + 1);
    localparam int G_DEPTH = N_IN * N_OUT;
    localparam int GAW   = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;

    // Input field unpacking.
    logic [amm_pkg::CHAN_W-1:0]    in_chan;
    logic [amm_pkg::CHAN_W-1:0]    out_chan;
    logic [amm_pkg::GAIN_W-1:0]    gain_value;
    logic [amm_pkg::SAMPLE_W-1:0]  sample_value;
    amm_pkg::t_func                func;

    assign in_chan      = i_s_tdata[2:0];
    assign out_chan     = i_s_tdata[5:3];
    assign gain_value   = i_s_tdata[21:6];
    assign sample_value = i_s_tdata[37:22];
    assign func         = amm_pkg::t_func'(i_s_tuser);

    // Control and configuration registers.
    amm_pkg::t_state               r_state, n_state;
    logic [amm_pkg::GAIN_W-1:0]    r_master;
    logic [3:0]                    r_active;
    logic [amm_pkg::GAIN_W-1:0]    r_vol [N_OUT];
    logic [amm_pkg::CHAN_W-1:0]    r_ic;
    logic signed [amm_pkg::SAMPLE_W-1:0] r_smp;
    logic                          r_eof;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_s1_v, r_s2_v;
    logic [AW-1:0]                 r_s1_o, r_s2_o;
    logic signed [32:0]            r_prod;
    logic [AW-1:0]                 r_eo;

    // Output register.
    logic                          r_out_v;
    logic [amm_pkg::CHAN_W-1:0]    r_out_idx;
    logic [amm_pkg::SAMPLE_W-1:0]  r_out_smp;
    logic                          r_out_clip;
    logic                          r_out_last;

    logic                          s_accept;
    logic                          issue;
    logic                          sweep_done;
    logic                          out_free;
    logic                          emit_load;
    logic                          emit_last;
    logic [CNT_W-1:0]              n_emit;
    logic                          gain_we;
    logic [GAW-1:0]                gain_waddr;
    logic [GAW-1:0]                gain_raddr;
    logic [amm_pkg::GAIN_W-1:0]    gain_rd;
    logic signed [32:0]            n_prod;
    logic                          acc_we;
    logic [AW-1:0]                 acc_raddr;
    logic [amm_pkg::ACC_W-1:0]     acc_rd;
    logic [amm_pkg::ACC_W-1:0]     acc_wdata;
    logic                          acc_clr;
    amm_pkg::t_scale_ctl           scale_ctl;
    logic [amm_pkg::GAIN_W-1:0]    master_sat;
    logic [amm_pkg::SAMPLE_W-1:0]  scaled;
    logic                          scaled_clip;

    assign o_s_tready  = (r_state == amm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;

    // Gain matrix writes happen on accepted gain items only.
    assign gain_we    = s_accept && (func == amm_pkg::FUNC_GAIN)
                        && (int'(in_chan) < N_IN) && (int'(out_chan) < N_OUT);
    assign gain_waddr = GAW'(int'(in_chan) * N_OUT + int'(out_chan));
    assign gain_raddr = GAW'(int'(r_ic) * N_OUT + int'(r_cnt));

    amm_gain_ram #(
        .DEPTH (G_DEPTH),
        .AW    (GAW)
    ) u_gain_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (gain_we),
        .i_wr_addr (gain_waddr),
        .i_wr_data (amm_pkg::sat_gain(gain_value)),
        .i_rd_addr (gain_raddr),
        .o_rd_data (gain_rd)
    );

    // Accumulation sweep: issue a gain read per output, multiply, then add.
    assign issue      = (r_state == amm_pkg::ST_ACC) && (r_cnt != CNT_W'(N_OUT));
    assign sweep_done = (r_cnt == CNT_W'(N_OUT)) && !r_s1_v && !r_s2_v;
    assign n_prod     = $signed({1'b0, gain_rd}) * r_smp;
    assign acc_we     = r_s2_v;
    assign acc_wdata  = acc_rd + {{(amm_pkg::ACC_W - 33){r_prod[32]}}, r_prod};
    assign acc_raddr  = (r_state == amm_pkg::ST_ACC) ? r_s1_o : r_eo;

    amm_acc_ram #(
        .DEPTH (N_OUT),
        .AW    (AW)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr_all (acc_clr),
        .i_wr_en   (acc_we),
        .i_wr_addr (r_s2_o),
        .i_wr_data (acc_wdata),
        .i_rd_addr (acc_raddr),
        .o_rd_data (acc_rd)
    );

    // Number of results per frame, clamped to the available outputs; zero gives one.
    always_comb begin
        if (r_active == 4'd0) begin
            n_emit = CNT_W'(1);
        end else if (int'(r_active) > N_OUT) begin
            n_emit = CNT_W'(N_OUT);
        end else begin
            n_emit = CNT_W'(r_active);
        end
    end

    assign master_sat = amm_pkg::sat_gain(r_master);
    assign out_free   = !r_out_v || i_m_tready;
    assign emit_last  = ((CNT_W'(r_eo) + CNT_W'(1)) == n_emit);
    assign emit_load  = (r_state == amm_pkg::ST_EMIT_WR) && out_free;
    assign acc_clr    = emit_load && emit_last;

    assign scale_ctl.ld_vol    = (r_state == amm_pkg::ST_EMIT_M1);
    assign scale_ctl.ld_master = (r_state == amm_pkg::ST_EMIT_M2);

    amm_scale u_scale (
        .i_clk    (i_clk),
        .i_ctl    (scale_ctl),
        .i_acc    (acc_rd),
        .i_vol    (r_vol[r_eo]),
        .i_master (master_sat),
        .o_sample (scaled),
        .o_clip   (scaled_clip)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amm_pkg::ST_IDLE: begin
                if (s_accept && (func == amm_pkg::FUNC_SAMPLE)) begin
                    if (int'(in_chan) < N_IN) begin
                        n_state = amm_pkg::ST_ACC;
                    end else if (i_s_tlast) begin
                        n_state = amm_pkg::ST_EMIT_RD;
                    end
                end
            end
            amm_pkg::ST_ACC: begin
                if (sweep_done) begin
                    n_state = r_eof ? amm_pkg::ST_EMIT_RD : amm_pkg::ST_IDLE;
                end
            end
            amm_pkg::ST_EMIT_RD: n_state = amm_pkg::ST_EMIT_M1;
            amm_pkg::ST_EMIT_M1: n_state = amm_pkg::ST_EMIT_M2;
            amm_pkg::ST_EMIT_M2: n_state = amm_pkg::ST_EMIT_WR;
            amm_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    n_state = emit_last ? amm_pkg::ST_IDLE : amm_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = amm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers and output volume table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= amm_pkg::UNITY;
            r_active <= 4'd8;
            for (int i = 0; i < N_OUT; i++) begin
                r_vol[i] <= amm_pkg::UNITY;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    amm_pkg::CFG_MASTER: r_master <= i_cfg_data;
                    amm_pkg::CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                endcase
            end
            if (s_accept && (func == amm_pkg::FUNC_VOL) && (int'(out_chan) < N_OUT)) begin
                r_vol[out_chan[AW-1:0]] <= amm_pkg::sat_gain(gain_value);
            end
        end
    end

    // Captured sample item, product register and sweep output indexes.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ic  <= in_chan;
            r_smp <= $signed(sample_value);
            r_eof <= i_s_tlast;
        end
        if (r_s1_v) begin
            r_prod <= n_prod;
        end
        r_s1_o <= r_cnt[AW-1:0];
        r_s2_o <= r_s1_o;
    end

    // Sweep counters, pipeline valids and emit index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_eo   <= '0;
        end else begin
            if (s_accept) begin
                r_cnt <= '0;
                r_eo  <= '0;
            end else begin
                if (issue) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (emit_load) begin
                    r_eo <= emit_last ? '0 : r_eo + AW'(1);
                end
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
        end
    end

    // Output register toward the master stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_idx  <= amm_pkg::CHAN_W'(r_eo);
            r_out_smp  <= scaled;
            r_out_clip <= scaled_clip;
            r_out_last <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {5'b0, r_out_smp, r_out_idx};
    assign o_m_tuser  = r_out_clip;
    assign o_m_tlast  = r_out_last;

    // Accumulators are written back only during a sample sweep.
    a_acc_we_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_we |-> (r_state == amm_pkg::ST_ACC))
        else $error("accumulator written outside a sweep");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    // The last result of a frame returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && emit_last) |=> (r_state == amm_pkg::ST_IDLE) && o_m_tlast)
        else $error("frame end did not return to idle");

    // Input is never taken while a sweep is still in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v || r_s2_v) |-> !o_s_tready)
        else $error("input ready during sweep");

endmodule
